[sv/srs_pkg.sv]
`timescale 1ns / 1ps
package srs_pkg;
	localparam int STACK_DEPTH_DEF = 128;
	localparam int PAIR_COUNT = 34;
	localparam int CP_W = 21;
	localparam int SC_W = 8;
	localparam int LEN_W = 16;
	localparam int PAIR_W = 6;
	localparam logic [SC_W-1:0] SC_COMMON = 8'd0;
	localparam logic [SC_W-1:0] SC_INHERITED = 8'd1;

	localparam logic [CP_W-1:0] PAIR_TABLE [PAIR_COUNT] = '{
		21'h0028, 21'h0029, 21'h003c, 21'h003e, 21'h005b, 21'h005d, 21'h007b, 21'h007d,
		21'h00ab, 21'h00bb, 21'h2018, 21'h2019, 21'h201c, 21'h201d, 21'h2039, 21'h203a,
		21'h3008, 21'h3009, 21'h300a, 21'h300b, 21'h300c, 21'h300d, 21'h300e, 21'h300f,
		21'h3010, 21'h3011, 21'h3014, 21'h3015, 21'h3016, 21'h3017, 21'h3018, 21'h3019,
		21'h301a, 21'h301b
	};

	typedef struct packed {
		logic             found;
		logic [PAIR_W-1:0] idx;
	} pair_hit_t;

	// Stack entry: pair index plus the run script at the time the opener was pushed.
	typedef struct packed {
		logic [PAIR_W-1:0] pair;
		logic [SC_W-1:0]   script;
	} entry_t;

	function automatic pair_hit_t pair_lookup(input logic [CP_W-1:0] cp);
		pair_hit_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int k = 0; k < PAIR_COUNT; k++) begin
			if (PAIR_TABLE[k] == cp) begin
				r.found = 1'b1;
				r.idx   = PAIR_W'(k);
			end
		end
		return r;
	endfunction

	function automatic logic is_real(input logic [SC_W-1:0] s);
		return s > SC_INHERITED;
	endfunction
endpackage

[sv/srs_if.sv]
`timescale 1ns / 1ps
interface srs_in_if;
	logic                          valid;
	logic                          ready;
	logic [srs_pkg::CP_W-1:0]      code_point;
	logic [srs_pkg::SC_W-1:0]      script_class;
	logic                          end_of_text;
	modport source (output valid, code_point, script_class, end_of_text, input ready);
	modport sink (input valid, code_point, script_class, end_of_text, output ready);
endinterface

interface srs_out_if;
	logic                          valid;
	logic                          ready;
	logic [srs_pkg::SC_W-1:0]      run_script;
	logic [srs_pkg::LEN_W-1:0]     run_chars;
	logic                          final_run;
	modport source (output valid, run_script, run_chars, final_run, input ready);
	modport sink (input valid, run_script, run_chars, final_run, output ready);
endinterface

[sv/script_run_segmenter.sv]
`timescale 1ns / 1ps
// Script run segmenter: one character per request in, finished runs out.
// Each character passes accept, search and evaluate before the next is taken, with one
// search step per opener dropped while a closer searches; a run break adds a break state
// and end of text an end state. Both wait while the output register is still full.
// Reset: arst_n clears stack, run state and output register asynchronously.
module script_run_segmenter #(
	parameter int STACK_DEPTH = srs_pkg::STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	srs_in_if.sink    in_ch,
	srs_out_if.source out_ch
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SRCH  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_BREAK = 3'd3;
	localparam logic [2:0] ST_EOT   = 3'd4;

	// Stack indexes are signed so that -1 means empty.
	localparam int TOP_W = $clog2(STACK_DEPTH) + 1;
	localparam logic signed [TOP_W-1:0] TOP_EMPTY = '1;
	localparam logic signed [TOP_W-1:0] TOP_LAST  = TOP_W'(STACK_DEPTH - 1);

	logic [2:0] state_q;
	logic [srs_pkg::SC_W-1:0] sc_q;
	logic eot_q;
	logic retry_q;
	srs_pkg::pair_hit_t hit_q;
	logic [srs_pkg::SC_W-1:0] cur_q;
	logic [srs_pkg::LEN_W-1:0] len_q;
	logic signed [TOP_W-1:0] top_q;
	logic signed [TOP_W-1:0] mark_q;
	logic ovalid_q;
	logic [srs_pkg::SC_W-1:0] oscript_q;
	logic [srs_pkg::LEN_W-1:0] olen_q;
	logic ofinal_q;

	srs_pkg::entry_t top;
	logic top_valid;
	logic s_push, s_pop, s_fix;
	srs_pkg::entry_t push_ent;
	logic signed [TOP_W:0] fix_cnt;
	logic signed [TOP_W-1:0] top_dec, top_inc, mark_fix, mark_pop;

	// Evaluation of the character against the current run.
	logic is_closer, is_opener, srch_pop, eff_real, cur_real_b, fix_now, brk;
	logic [srs_pkg::SC_W-1:0] eff_sc, run_next;
	logic out_free, emit;

	srs_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .arst_n(arst_n), .push(s_push), .push_ent(push_ent),
		.pop(s_pop), .fix_all(s_fix), .fix_cnt(fix_cnt),
		.fix_script(eff_sc), .top(top)
	);

	assign top_valid = !top_q[TOP_W-1];
	assign top_dec   = top_q - TOP_W'(1);
	// A push past the last cell wraps the index back to the bottom entry.
	assign top_inc   = (top_q == TOP_LAST) ? '0 : top_q + TOP_W'(1);
	// Entries above the mark still carry the script from before the run turned real.
	assign fix_cnt   = {top_q[TOP_W-1], top_q} - {mark_q[TOP_W-1], mark_q};

	assign out_free  = !ovalid_q || out_ch.ready;
	assign emit      = ((state_q == ST_BREAK) || (state_q == ST_EOT)) && out_free;
	assign is_opener = hit_q.found && !hit_q.idx[0];
	assign is_closer = hit_q.found && hit_q.idx[0];
	// Drop entries until the top holds the matching opener or the stack is empty.
	assign srch_pop  = is_closer && top_valid &&
		(top.pair != hit_q.idx - srs_pkg::PAIR_W'(1));
	assign eff_sc    = (is_closer && top_valid) ? top.script : sc_q;
	assign cur_real_b = srs_pkg::is_real(cur_q);
	assign eff_real  = srs_pkg::is_real(eff_sc);
	assign brk       = cur_real_b && eff_real && (cur_q != eff_sc);
	assign fix_now   = !cur_real_b && eff_real;
	assign run_next  = fix_now ? eff_sc : cur_q;
	assign push_ent  = '{pair: hit_q.idx, script: cur_q};
	// The mark only ever moves up to the top; a wrapped stack can leave it higher.
	assign mark_fix  = (fix_now && (mark_q < top_q)) ? top_q : mark_q;
	assign mark_pop  = (top_dec < mark_fix) ? top_dec : mark_fix;

	assign in_ch.ready = (state_q == ST_IDLE);

	always_comb begin
		s_push = 1'b0; s_pop = 1'b0; s_fix = 1'b0;
		unique case (state_q)
			ST_SRCH: begin
				s_pop = srch_pop;
			end
			ST_EVAL: begin
				// Fix-up and the closer's own pop may share a cycle.
				if (!brk) begin
					s_fix  = fix_now;
					s_push = is_opener;
					s_pop  = is_closer && top_valid;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sc_q      <= srs_pkg::SC_COMMON;
			eot_q     <= 1'b0;
			hit_q     <= '0;
			cur_q     <= srs_pkg::SC_COMMON;
			len_q     <= '0;
			top_q     <= TOP_EMPTY;
			mark_q    <= TOP_EMPTY;
			ovalid_q  <= 1'b0;
			oscript_q <= '0;
			olen_q    <= '0;
			ofinal_q  <= 1'b0;
			retry_q   <= 1'b0;
		end else begin
			if (emit) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						sc_q    <= in_ch.script_class;
						eot_q   <= in_ch.end_of_text;
						hit_q   <= (in_ch.script_class == srs_pkg::SC_COMMON) ?
							srs_pkg::pair_lookup(in_ch.code_point) : '0;
						retry_q <= 1'b0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (srch_pop) begin
						top_q  <= top_dec;
						mark_q <= (top_dec < mark_q) ? top_dec : mark_q;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (brk) begin
						state_q <= ST_BREAK;
					end else begin
						cur_q <= run_next;
						if (s_push) top_q <= top_inc;
						else if (s_pop) top_q <= top_dec;
						mark_q <= s_pop ? mark_pop : mark_fix;
						if (len_q != '1) len_q <= len_q + srs_pkg::LEN_W'(1);
						state_q <= eot_q ? ST_EOT : ST_IDLE;
					end
				end
				ST_BREAK: begin
					// Emit the broken run, then evaluate the character again.
					if (out_free) begin
						oscript_q <= cur_q;
						olen_q    <= len_q;
						ofinal_q  <= 1'b0;
						cur_q     <= srs_pkg::SC_COMMON;
						len_q     <= '0;
						mark_q    <= top_q;
						retry_q   <= 1'b1;
						state_q   <= ST_EVAL;
					end
				end
				ST_EOT: begin
					if (out_free) begin
						oscript_q <= cur_q;
						olen_q    <= len_q;
						ofinal_q  <= 1'b1;
						cur_q     <= srs_pkg::SC_COMMON;
						len_q     <= '0;
						top_q     <= TOP_EMPTY;
						mark_q    <= TOP_EMPTY;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.run_script = oscript_q;
	assign out_ch.run_chars  = olen_q;
	assign out_ch.final_run  = ofinal_q;

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EOT && out_free) |=> (len_q == '0 && cur_q == srs_pkg::SC_COMMON))
		else $error("run state not cleared at end of text");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (state_q == ST_IDLE))
		else $error("request taken while busy");
	a_out_len: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (olen_q != '0))
		else $error("empty run emitted");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ch.ready) |=> (ovalid_q && $stable(olen_q) &&
			$stable(oscript_q) && $stable(ofinal_q)))
		else $error("run result changed while waiting");
	a_retry_nobreak: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && retry_q) |-> !brk)
		else $error("fresh run broke again");
endmodule

[sv/srs_cell.sv]
`timescale 1ns / 1ps
// One stack slot. Shift toward the bottom on push, toward the top on pop.
module srs_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            pop,
	input  logic            wr_script,
	input  logic [srs_pkg::SC_W-1:0] new_script,
	input  srs_pkg::entry_t from_up,
	input  srs_pkg::entry_t from_down,
	output srs_pkg::entry_t ent
);
	srs_pkg::entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (push) begin
			ent_q <= from_down;
		end else if (pop) begin
			ent_q <= from_up;
		end else if (wr_script) begin
			ent_q.script <= new_script;
		end
	end

	assign ent = ent_q;
endmodule

[sv/srs_stack.sv]
`timescale 1ns / 1ps
// Chain of cells; cell 0 is the top of stack. Occupancy and the fix-up mark
// live in the controller; fix_cnt tells how many cells from the top still
// need the run script.
module srs_stack #(
	parameter int STACK_DEPTH = srs_pkg::STACK_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  srs_pkg::entry_t push_ent,
	input  logic            pop,
	input  logic            fix_all,
	input  logic signed [$clog2(STACK_DEPTH)+1:0] fix_cnt,
	input  logic [srs_pkg::SC_W-1:0] fix_script,
	output srs_pkg::entry_t top
);
	localparam int CNT_W = $clog2(STACK_DEPTH) + 2;

	srs_pkg::entry_t        ent [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] fix_en;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		localparam logic signed [CNT_W-1:0] IDX = CNT_W'(i);
		srs_pkg::entry_t up_e, dn_e;

		assign fix_en[i] = fix_all && (fix_cnt > IDX);

		if (i == 0) begin : g_top
			assign dn_e = push_ent;
		end else begin : g_mid
			assign dn_e = ent[i-1];
		end
		// A cell that moves up while being fixed carries the new script along.
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign up_e = '0;
		end else begin : g_up
			assign up_e = fix_en[i+1] ? '{pair: ent[i+1].pair, script: fix_script} :
				ent[i+1];
		end
		srs_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.push(push), .pop(pop),
			.wr_script(fix_en[i]),
			.new_script(fix_script),
			.from_up(up_e), .from_down(dn_e),
			.ent(ent[i])
		);
	end

	assign top = ent[0];
endmodule
